FILE: rtl/core/y86sd_pkg.sv
// shared types, constants and opcode length decode for the y86 stream decoder
`default_nettype none

package y86sd_pkg;

    // width of the running byte offset counter (8 to 32)
    localparam int OFFSET_BITS = 32;

    // instruction lengths in bytes
    localparam logic [2:0] LEN_NONE    = 3'd0;
    localparam logic [2:0] LEN_OP      = 3'd1;
    localparam logic [2:0] LEN_REG     = 3'd2;
    localparam logic [2:0] LEN_IMM     = 3'd5;
    localparam logic [2:0] LEN_REG_IMM = 3'd6;

    // icode values (high nibble of the opcode)
    localparam logic [3:0] IC_NOP    = 4'h0;
    localparam logic [3:0] IC_HALT   = 4'h1;
    localparam logic [3:0] IC_RRMOVL = 4'h2;
    localparam logic [3:0] IC_IRMOVL = 4'h3;
    localparam logic [3:0] IC_RMMOVL = 4'h4;
    localparam logic [3:0] IC_MRMOVL = 4'h5;
    localparam logic [3:0] IC_OPL    = 4'h6;
    localparam logic [3:0] IC_JXX    = 4'h7;
    localparam logic [3:0] IC_CALL   = 4'h8;
    localparam logic [3:0] IC_RET    = 4'h9;
    localparam logic [3:0] IC_PUSHL  = 4'ha;
    localparam logic [3:0] IC_POPL   = 4'hb;
    localparam logic [3:0] IC_EXT_C  = 4'hc;
    localparam logic [3:0] IC_EXT_D  = 4'hd;
    localparam logic [3:0] IC_EXT_E  = 4'he;

    // highest valid function code per family
    localparam logic [3:0] IFUN_OPL_MAX = 4'h5;
    localparam logic [3:0] IFUN_JXX_MAX = 4'h6;
    localparam logic [3:0] IFUN_EXT_MAX = 4'h1;
    localparam logic [3:0] IFUN_PLAIN   = 4'h0;

    // one decoded instruction
    typedef struct packed {
        logic [31:0] start_offset;
        logic [7:0]  opcode;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [31:0] immediate;
        logic [2:0]  length;
        logic        invalid;
    } t_result;

    // instruction length for an opcode, zero when unknown
    function automatic logic [2:0] length_of(input logic [7:0] op);
        logic [3:0] icode;
        logic [3:0] ifun;
        logic [2:0] len;
        icode = op[7:4];
        ifun  = op[3:0];
        len   = LEN_NONE;
        unique case (icode) inside
            IC_NOP, IC_HALT, IC_RET: begin
                if (ifun == IFUN_PLAIN) len = LEN_OP;
            end
            IC_RRMOVL, IC_PUSHL, IC_POPL: begin
                if (ifun == IFUN_PLAIN) len = LEN_REG;
            end
            IC_OPL: begin
                if (ifun <= IFUN_OPL_MAX) len = LEN_REG;
            end
            IC_JXX: begin
                if (ifun <= IFUN_JXX_MAX) len = LEN_IMM;
            end
            IC_CALL: begin
                if (ifun == IFUN_PLAIN) len = LEN_IMM;
            end
            IC_IRMOVL, IC_RMMOVL, IC_MRMOVL, IC_EXT_E: begin
                if (ifun == IFUN_PLAIN) len = LEN_REG_IMM;
            end
            IC_EXT_C, IC_EXT_D: begin
                if (ifun <= IFUN_EXT_MAX) len = LEN_REG_IMM;
            end
            default: begin
                len = LEN_NONE;
            end
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/y86sd_framer.sv
// byte framing state and instruction assembly
`default_nettype none

module y86sd_framer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_byte,
    input  wire logic [31:0]          i_code_length,
    output logic                      o_res_valid,
    output y86sd_pkg::t_result        o_res
);

    logic [2:0]                       r_rem;
    logic [2:0]                       r_len;
    logic [7:0]                       r_op;
    logic [7:0]                       r_reg;
    logic [31:0]                      r_imm;
    logic [31:0]                      r_start;
    logic [y86sd_pkg::OFFSET_BITS-1:0] r_byte_offset;
    logic                             r_stopped;

    logic [2:0]  n_rem;
    logic [2:0]  n_len;
    logic [7:0]  n_op;
    logic [7:0]  n_reg;
    logic [31:0] n_imm;
    logic [31:0] n_start;
    logic        n_stopped;
    logic [31:0] here;
    logic [2:0]  op_len;

    assign here   = 32'(r_byte_offset);
    assign op_len = y86sd_pkg::length_of(i_byte);

    always_comb begin
        n_rem       = r_rem;
        n_len       = r_len;
        n_op        = r_op;
        n_reg       = r_reg;
        n_imm       = r_imm;
        n_start     = r_start;
        n_stopped   = r_stopped;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept && !r_stopped) begin
            if (r_rem == 3'd0) begin
                // opcode byte, only below the code length
                if (here < i_code_length) begin
                    n_start = here;
                    n_op    = i_byte;
                    n_reg   = '0;
                    n_imm   = '0;
                    n_len   = op_len;
                    o_res.start_offset = here;
                    o_res.opcode       = i_byte;
                    o_res.length       = op_len;
                    if (op_len == y86sd_pkg::LEN_NONE) begin
                        n_stopped     = 1'b1;
                        o_res.invalid = 1'b1;
                        o_res_valid   = 1'b1;
                    end else if (op_len == y86sd_pkg::LEN_OP) begin
                        o_res_valid = 1'b1;
                    end else begin
                        n_rem = op_len - 3'd1;
                    end
                end
            end else begin
                // second byte of a register format is the register byte
                if ((r_len == y86sd_pkg::LEN_REG || r_len == y86sd_pkg::LEN_REG_IMM) &&
                    (r_rem == r_len - 3'd1)) begin
                    n_reg = i_byte;
                end else begin
                    n_imm = {i_byte, r_imm[31:8]};
                end
                n_rem = r_rem - 3'd1;
                o_res.start_offset = r_start;
                o_res.opcode       = r_op;
                o_res.reg_a        = n_reg[7:4];
                o_res.reg_b        = n_reg[3:0];
                o_res.immediate    = n_imm;
                o_res.length       = r_len;
                o_res_valid        = (n_rem == 3'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem         <= '0;
            r_stopped     <= 1'b0;
            r_byte_offset <= '0;
        end else begin
            r_rem     <= n_rem;
            r_stopped <= n_stopped;
            if (i_accept) begin
                r_byte_offset <= r_byte_offset + y86sd_pkg::OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_op    <= n_op;
        r_reg   <= n_reg;
        r_imm   <= n_imm;
        r_start <= n_start;
    end

endmodule

`default_nettype wire

FILE: rtl/core/y86sd_out_buf.sv
// two-entry result queue between framer and output channel
`default_nettype none

module y86sd_out_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire y86sd_pkg::t_result   i_wr_data,
    output logic                      o_has_space,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output y86sd_pkg::t_result        o_data
);

    y86sd_pkg::t_result r_mem [2];
    logic [1:0] r_count;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic       rd;

    assign o_has_space = (r_count != 2'd2);
    assign o_valid     = (r_count != 2'd0);
    assign o_data      = r_mem[r_rd_ptr];
    assign rd          = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= r_count + {1'b0, i_wr} - {1'b0, rd};
            if (i_wr) r_wr_ptr <= ~r_wr_ptr;
            if (rd)   r_rd_ptr <= ~r_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/y86_instruction_stream_decoder.sv
// top level of the y86 instruction stream decoder
`default_nettype none

// Takes the code section one byte per item on the slave stream and frames it into
// 1, 2, 5 or 6 byte instructions of the extended y86 set. One result item leaves per
// complete instruction, carrying start offset, opcode, register nibbles (zero when the
// format has no register byte), the little-endian 32-bit immediate (zero when none) and
// the length. An unknown opcode gives one result with tuser set and length zero, then
// every further byte is swallowed without result until reset. Opcode bytes at offsets
// at or past code_length are dropped; an instruction started below it takes all its
// bytes. The byte offset counts every accepted byte and wraps. Throughput is one byte
// per cycle while the queue has room; the framer state updates on each accepted byte,
// and a result enters the two-entry output queue on the edge taking the last byte and
// is offered on the master side in the next cycle. Input is held off only while both
// entries wait. code_length is to be written while the stream is idle (not enforced).
module y86_instruction_stream_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: code_length
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    // input bytes
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // code_byte
    // decoded instructions
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [31:0] start_offset, [39:32] opcode, [43:40] reg_a, [47:44] reg_b,
    // [79:48] immediate, [82:80] length, [87:83] zero
    output logic [87:0]      o_m_axis_tdata,
    output logic             o_m_axis_tuser    // invalid
);

    logic [31:0]        r_code_length;
    logic               s_accept;
    logic               res_valid;
    y86sd_pkg::t_result res;
    y86sd_pkg::t_result out_res;
    logic               has_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length <= '0;
        end else if (i_cfg_wr_en) begin
            r_code_length <= i_cfg_wr_data;
        end
    end

    // accept while the queue has a free entry
    assign o_s_axis_tready = has_space;
    assign s_accept        = i_s_axis_tvalid && has_space;

    y86sd_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_byte        (i_s_axis_tdata),
        .i_code_length (r_code_length),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    y86sd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (res_valid),
        .i_wr_data   (res),
        .o_has_space (has_space),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (out_res)
    );

    // pack result fields, lowest first
    assign o_m_axis_tdata = {5'd0, out_res.length, out_res.immediate, out_res.reg_b,
                             out_res.reg_a, out_res.opcode, out_res.start_offset};
    assign o_m_axis_tuser = out_res.invalid;

    // input only stalls when results are backed up on the output
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result pending");

    // an invalid result has length zero
    a_invalid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[82:80] == 3'd0))
        else $error("invalid result with nonzero length");

    // a valid result has one of the legal lengths
    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
            (o_m_axis_tdata[82:80] == y86sd_pkg::LEN_OP ||
             o_m_axis_tdata[82:80] == y86sd_pkg::LEN_REG ||
             o_m_axis_tdata[82:80] == y86sd_pkg::LEN_IMM ||
             o_m_axis_tdata[82:80] == y86sd_pkg::LEN_REG_IMM))
        else $error("result with illegal length");

    // formats without a register byte report zero nibbles
    a_no_reg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[82:80] == y86sd_pkg::LEN_OP ||
                             o_m_axis_tdata[82:80] == y86sd_pkg::LEN_IMM ||
                             o_m_axis_tdata[82:80] == y86sd_pkg::LEN_NONE))
        |-> (o_m_axis_tdata[47:40] == 8'd0))
        else $error("register nibbles set for a format without register byte");

endmodule

`default_nettype wire
